FILE: src/brs_pkg.sv
// Shared types, constants and codes of the block request splitter.
`timescale 1ns / 1ps

package brs_pkg;

  localparam int CHUNK_SECTORS      = 256;
  localparam int MAX_RUN_SEGMENTS   = 1024;
  localparam int MAX_BATCH_SEGMENTS = 64;
  localparam int COUNT_LIMIT        = 8192;

  localparam int SECTOR_W   = 48;
  localparam int COUNT_W    = 14;
  localparam int CMD_CNT_W  = 16;
  localparam int OFFSET_W   = 13;
  localparam int SEG_IDX_W  = 10;
  localparam int SEG_TOT_W  = 7;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [1:0] {
    OP_READ     = 2'd0,
    OP_WRITE    = 2'd1,
    OP_SEGMENT  = 2'd2,
    OP_RESERVED = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_DONE   = 3'd0,
    KIND_READ   = 3'd1,
    KIND_WRITE  = 3'd2,
    KIND_WRITEV = 3'd3,
    KIND_GONE   = 3'd4,
    KIND_BIG    = 3'd5,
    KIND_UNSUP  = 3'd6
  } cmd_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PARTITION_BASE = 3'd0,
    CFG_DEVICE_GONE    = 3'd1,
    CFG_WRITE_ALLOWED  = 3'd2,
    CFG_BATCH_SEGS     = 3'd3,
    CFG_BATCH_SECTORS  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ALU_START_BASE,
    ALU_CHUNK_ADDR,
    ALU_CURSOR_ADV
  } alu_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ERROR,
    ST_DONE,
    ST_SEG,
    ST_PRE,
    ST_BIGFLUSH,
    ST_CHUNK,
    ST_ADV,
    ST_FINAL
  } state_e;

  typedef struct packed {
    logic [SECTOR_W-1:0] partition_base;
    logic                device_gone;
    logic                write_allowed;
    logic [6:0]          batch_max_segments;
    logic [15:0]         batch_max_sectors;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e            kind;
    logic [SECTOR_W-1:0]  sector;
    logic [CMD_CNT_W-1:0] count;
    logic [OFFSET_W-1:0]  offset;
    logic [SEG_IDX_W-1:0] first;
    logic [SEG_TOT_W-1:0] total;
    logic                 last;
  } res_t;

endpackage

FILE: src/brs_alu.sv
// Shared 48-bit sector adder with its operand selection.
`timescale 1ns / 1ps

module brs_alu (
  input  brs_pkg::alu_sel_e                   sel_i,
  input  logic [brs_pkg::SECTOR_W-1:0]        start_i,
  input  logic [brs_pkg::SECTOR_W-1:0]        base_i,
  input  logic [brs_pkg::SECTOR_W-1:0]        chunk_base_i,
  input  logic [brs_pkg::COUNT_W-1:0]         offset_i,
  input  logic [brs_pkg::SECTOR_W-1:0]        cursor_i,
  input  logic [brs_pkg::COUNT_W-1:0]         count_i,
  output logic [brs_pkg::SECTOR_W-1:0]        sum_o
);

  logic [brs_pkg::SECTOR_W-1:0] a;
  logic [brs_pkg::SECTOR_W-1:0] b;

  always_comb begin
    case (sel_i)
      brs_pkg::ALU_START_BASE: begin
        a = start_i;
        b = base_i;
      end
      brs_pkg::ALU_CHUNK_ADDR: begin
        a = chunk_base_i;
        b = brs_pkg::SECTOR_W'(offset_i);
      end
      brs_pkg::ALU_CURSOR_ADV: begin
        a = cursor_i;
        b = brs_pkg::SECTOR_W'(count_i);
      end
      default: begin
        a = start_i;
        b = base_i;
      end
    endcase
  end

  // Sector addresses wrap at 48 bits.
  assign sum_o = a + b;

endmodule

FILE: src/brs_ctrl.sv
// Sequencer that walks one request through decode, chunking and batching.
`timescale 1ns / 1ps

module brs_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  brs_pkg::cfg_t                     cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        operation_i,
  input  logic [brs_pkg::SECTOR_W-1:0]      start_i,
  input  logic [brs_pkg::COUNT_W-1:0]       count_i,
  input  logic                              last_i,
  output logic                              res_valid_o,
  output brs_pkg::res_t                     res_o,
  input  logic                              res_ready_i
);

  brs_pkg::state_e state_q, state_d;

  brs_pkg::op_e                   op_q;
  logic [brs_pkg::SECTOR_W-1:0]   start_q;
  logic [brs_pkg::COUNT_W-1:0]    cnt_q;
  logic                           last_q;
  logic [brs_pkg::SECTOR_W-1:0]   abs_q, abs_d;
  logic [brs_pkg::COUNT_W-1:0]    off_q, off_d;
  brs_pkg::cmd_kind_e             err_kind_q, err_kind_d;

  logic                           run_active_q, run_active_d;
  logic [brs_pkg::SECTOR_W-1:0]   cursor_q, cursor_d;
  logic [brs_pkg::SEG_IDX_W-1:0]  idx_q, idx_d;
  logic [brs_pkg::SECTOR_W-1:0]   psector_q, psector_d;
  logic [brs_pkg::SEG_IDX_W-1:0]  pfirst_q, pfirst_d;
  logic [brs_pkg::SEG_TOT_W-1:0]  pseg_q, pseg_d;
  logic [15:0]                    psec_q, psec_d;

  brs_pkg::alu_sel_e              alu_sel;
  logic [brs_pkg::SECTOR_W-1:0]   alu_sum;
  logic [brs_pkg::SECTOR_W-1:0]   chunk_base;

  logic [6:0]                     seg_limit;
  logic                           seg_disabled;
  logic                           too_big;
  logic                           chunk_seg;
  logic                           pre_flush;
  logic [brs_pkg::COUNT_W-1:0]    left;
  logic [brs_pkg::COUNT_W-1:0]    chunk_len;
  logic                           chunk_final;
  logic [brs_pkg::SEG_IDX_W-1:0]  idx_next;
  logic                           take;
  brs_pkg::res_t                  flush_res;

  assign chunk_base = (op_q == brs_pkg::OP_SEGMENT) ? cursor_q : abs_q;

  brs_alu u_alu (
    .sel_i        (alu_sel),
    .start_i      (start_q),
    .base_i       (cfg_i.partition_base),
    .chunk_base_i (chunk_base),
    .offset_i     (off_q),
    .cursor_i     (cursor_q),
    .count_i      (cnt_q),
    .sum_o        (alu_sum)
  );

  assign seg_limit = (cfg_i.batch_max_segments > 7'(brs_pkg::MAX_BATCH_SEGMENTS)) ?
                     7'(brs_pkg::MAX_BATCH_SEGMENTS) : cfg_i.batch_max_segments;
  assign seg_disabled = !cfg_i.write_allowed || (seg_limit == '0) ||
                        (cfg_i.batch_max_sectors == '0);
  assign too_big   = cnt_q > brs_pkg::COUNT_W'(brs_pkg::COUNT_LIMIT);
  assign chunk_seg = 16'(cnt_q) > cfg_i.batch_max_sectors;
  // The open batch is closed before this segment when it is full or would overflow.
  assign pre_flush = (pseg_q != '0) &&
                     ((pseg_q >= seg_limit) ||
                      ((17'(psec_q) + 17'(cnt_q)) > 17'(cfg_i.batch_max_sectors)));

  assign left        = cnt_q - off_q;
  assign chunk_final = left <= brs_pkg::COUNT_W'(brs_pkg::CHUNK_SECTORS);
  assign chunk_len   = chunk_final ? left : brs_pkg::COUNT_W'(brs_pkg::CHUNK_SECTORS);
  assign idx_next    = (idx_q == brs_pkg::SEG_IDX_W'(brs_pkg::MAX_RUN_SEGMENTS - 1)) ?
                       '0 : idx_q + brs_pkg::SEG_IDX_W'(1);

  always_comb begin
    flush_res        = '0;
    flush_res.kind   = (pseg_q == 7'd1) ? brs_pkg::KIND_WRITE : brs_pkg::KIND_WRITEV;
    flush_res.sector = psector_q;
    flush_res.count  = psec_q;
    flush_res.first  = pfirst_q;
    flush_res.total  = pseg_q;
  end

  assign in_stall_o = (state_q != brs_pkg::ST_IDLE);
  assign take       = res_valid_o && res_ready_i;

  always_comb begin
    state_d      = state_q;
    abs_d        = abs_q;
    off_d        = off_q;
    err_kind_d   = err_kind_q;
    run_active_d = run_active_q;
    cursor_d     = cursor_q;
    idx_d        = idx_q;
    psector_d    = psector_q;
    pfirst_d     = pfirst_q;
    pseg_d       = pseg_q;
    psec_d       = psec_q;
    alu_sel      = brs_pkg::ALU_START_BASE;
    res_valid_o  = 1'b0;
    res_o        = '0;

    case (state_q)
      brs_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = brs_pkg::ST_DECODE;
        end
      end

      brs_pkg::ST_DECODE: begin
        alu_sel = brs_pkg::ALU_START_BASE;
        abs_d   = alu_sum;
        off_d   = '0;
        state_d = brs_pkg::ST_ERROR;
        case (op_q)
          brs_pkg::OP_READ, brs_pkg::OP_WRITE: begin
            if (op_q == brs_pkg::OP_WRITE && !cfg_i.write_allowed) begin
              err_kind_d = brs_pkg::KIND_UNSUP;
            end else if (cfg_i.device_gone) begin
              err_kind_d = brs_pkg::KIND_GONE;
            end else if (too_big) begin
              err_kind_d = brs_pkg::KIND_BIG;
            end else if (cnt_q == '0) begin
              state_d = brs_pkg::ST_DONE;
            end else begin
              state_d = brs_pkg::ST_CHUNK;
            end
          end
          brs_pkg::OP_SEGMENT: begin
            if (seg_disabled || cfg_i.device_gone) begin
              // A failing segment drops the open run and its batch.
              err_kind_d   = seg_disabled ? brs_pkg::KIND_UNSUP : brs_pkg::KIND_GONE;
              run_active_d = 1'b0;
              pseg_d       = '0;
              psec_d       = '0;
            end else begin
              if (!run_active_q) begin
                run_active_d = 1'b1;
                cursor_d     = alu_sum;
                idx_d        = '0;
                pseg_d       = '0;
                psec_d       = '0;
              end
              state_d = brs_pkg::ST_SEG;
            end
          end
          default: begin
            err_kind_d = brs_pkg::KIND_UNSUP;
          end
        endcase
      end

      brs_pkg::ST_ERROR: begin
        res_valid_o = 1'b1;
        res_o.kind  = err_kind_q;
        res_o.count = 16'(cnt_q);
        res_o.last  = 1'b1;
        if (take) begin
          state_d = brs_pkg::ST_IDLE;
        end
      end

      brs_pkg::ST_DONE: begin
        res_valid_o  = 1'b1;
        res_o.kind   = brs_pkg::KIND_DONE;
        res_o.sector = abs_q;
        res_o.total  = 7'd1;
        res_o.last   = 1'b1;
        if (take) begin
          state_d = brs_pkg::ST_IDLE;
        end
      end

      brs_pkg::ST_SEG: begin
        if (too_big) begin
          err_kind_d = brs_pkg::KIND_BIG;
          state_d    = brs_pkg::ST_ERROR;
          if (last_q) begin
            run_active_d = 1'b0;
            if (pseg_q != '0) begin
              state_d = brs_pkg::ST_BIGFLUSH;
            end
          end
        end else if (pre_flush) begin
          state_d = brs_pkg::ST_PRE;
        end else if (chunk_seg) begin
          state_d = brs_pkg::ST_CHUNK;
        end else begin
          state_d = brs_pkg::ST_ADV;
        end
      end

      brs_pkg::ST_PRE: begin
        res_valid_o = 1'b1;
        res_o       = flush_res;
        // Nothing follows when the segment is absorbed and the run goes on.
        res_o.last  = !chunk_seg && !last_q;
        if (take) begin
          pseg_d  = '0;
          psec_d  = '0;
          state_d = chunk_seg ? brs_pkg::ST_CHUNK : brs_pkg::ST_ADV;
        end
      end

      brs_pkg::ST_BIGFLUSH: begin
        res_valid_o = 1'b1;
        res_o       = flush_res;
        res_o.last  = 1'b0;
        if (take) begin
          pseg_d  = '0;
          psec_d  = '0;
          state_d = brs_pkg::ST_ERROR;
        end
      end

      brs_pkg::ST_CHUNK: begin
        alu_sel      = brs_pkg::ALU_CHUNK_ADDR;
        res_valid_o  = 1'b1;
        res_o.kind   = (op_q == brs_pkg::OP_READ) ? brs_pkg::KIND_READ : brs_pkg::KIND_WRITE;
        res_o.sector = alu_sum;
        res_o.count  = 16'(chunk_len);
        res_o.offset = off_q[brs_pkg::OFFSET_W-1:0];
        res_o.first  = (op_q == brs_pkg::OP_SEGMENT) ? idx_q : '0;
        res_o.total  = 7'd1;
        res_o.last   = chunk_final;
        if (take) begin
          off_d = off_q + chunk_len;
          if (chunk_final) begin
            state_d = (op_q == brs_pkg::OP_SEGMENT) ? brs_pkg::ST_ADV : brs_pkg::ST_IDLE;
          end
        end
      end

      brs_pkg::ST_ADV: begin
        alu_sel  = brs_pkg::ALU_CURSOR_ADV;
        cursor_d = alu_sum;
        idx_d    = idx_next;
        if (!chunk_seg) begin
          if (pseg_q == '0) begin
            psector_d = cursor_q;
            pfirst_d  = idx_q;
          end
          pseg_d = pseg_q + 7'd1;
          psec_d = psec_q + 16'(cnt_q);
        end
        state_d = brs_pkg::ST_IDLE;
        if (last_q) begin
          run_active_d = 1'b0;
          if (!chunk_seg) begin
            state_d = brs_pkg::ST_FINAL;
          end
        end
      end

      brs_pkg::ST_FINAL: begin
        res_valid_o = 1'b1;
        res_o       = flush_res;
        res_o.last  = 1'b1;
        if (take) begin
          pseg_d  = '0;
          psec_d  = '0;
          state_d = brs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = brs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= brs_pkg::ST_IDLE;
      run_active_q <= 1'b0;
      cursor_q     <= '0;
      idx_q        <= '0;
      psector_q    <= '0;
      pfirst_q     <= '0;
      pseg_q       <= '0;
      psec_q       <= '0;
    end else begin
      state_q      <= state_d;
      run_active_q <= run_active_d;
      cursor_q     <= cursor_d;
      idx_q        <= idx_d;
      psector_q    <= psector_d;
      pfirst_q     <= pfirst_d;
      pseg_q       <= pseg_d;
      psec_q       <= psec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == brs_pkg::ST_IDLE && in_valid_i) begin
      op_q    <= brs_pkg::op_e'(operation_i);
      start_q <= start_i;
      cnt_q   <= count_i;
      last_q  <= last_i;
    end
    abs_q      <= abs_d;
    off_q      <= off_d;
    err_kind_q <= err_kind_d;
  end

endmodule

FILE: src/block_request_splitter.sv
// Top level of the block request splitter: configuration, sequencer and result register.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_stall_o   operation, start_sector, num_sectors,
//                                               last_segment
//   out      output     out_valid_o/out_stall_i cmd_kind ... last_of_run
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A read or write is accepted, decoded and then gives one result per chunk; a
// request of N sectors (1 to 8192) gives ceil(N/256) results. A vectored segment
// is accepted, decoded and checked, may first close an open batch, is then chunked
// or added to the batch, and the cursor advances; the last segment of a run closes the batch.
// The sequencer has a single result port and one shared sector adder.
// Reset is asynchronous and clears the run and batch state; a stall on the result
// side holds the sequencer, and no new request is taken until the last result
// of the current one has left the sequencer.
`timescale 1ns / 1ps

module block_request_splitter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          operation_i,
  input  logic [brs_pkg::SECTOR_W-1:0]        start_sector_i,
  input  logic [brs_pkg::COUNT_W-1:0]         num_sectors_i,
  input  logic                                last_segment_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [2:0]                          cmd_kind_o,
  output logic [brs_pkg::SECTOR_W-1:0]        cmd_sector_o,
  output logic [brs_pkg::CMD_CNT_W-1:0]       cmd_count_o,
  output logic [brs_pkg::OFFSET_W-1:0]        buffer_offset_o,
  output logic [brs_pkg::SEG_IDX_W-1:0]       first_segment_o,
  output logic [brs_pkg::SEG_TOT_W-1:0]       segment_total_o,
  output logic                                last_of_run_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [brs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [brs_pkg::SECTOR_W-1:0]        cfg_data_i
);

  brs_pkg::cfg_t cfg_q;
  brs_pkg::res_t res;
  brs_pkg::res_t out_q;
  logic          res_valid;
  logic          res_ready;
  logic          out_valid_q;

  // Writes must come only while the block is idle; the block does not enforce this, and the port is always open.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        brs_pkg::CFG_PARTITION_BASE: cfg_q.partition_base     <= cfg_data_i;
        brs_pkg::CFG_DEVICE_GONE:    cfg_q.device_gone        <= cfg_data_i[0];
        brs_pkg::CFG_WRITE_ALLOWED:  cfg_q.write_allowed      <= cfg_data_i[0];
        brs_pkg::CFG_BATCH_SEGS:     cfg_q.batch_max_segments <= cfg_data_i[6:0];
        brs_pkg::CFG_BATCH_SECTORS:  cfg_q.batch_max_sectors  <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  brs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .start_i     (start_sector_i),
    .count_i     (num_sectors_i),
    .last_i      (last_segment_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // The result register takes a new transaction when empty or being drained.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cmd_kind_o      = out_q.kind;
  assign cmd_sector_o    = out_q.sector;
  assign cmd_count_o     = out_q.count;
  assign buffer_offset_o = out_q.offset;
  assign first_segment_o = out_q.first;
  assign segment_total_o = out_q.total;
  assign last_of_run_o   = out_q.last;

  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o
  ) else $error("request accepted while the sequencer stays open");

  a_batch_total_bound: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (segment_total_o <= 7'(brs_pkg::MAX_BATCH_SEGMENTS))
  ) else $error("vectored command covers too many segments");

  a_read_chunk_size: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (cmd_kind_o == 3'(brs_pkg::KIND_READ))) |->
      ((cmd_count_o != '0) && (cmd_count_o <= 16'(brs_pkg::CHUNK_SECTORS)))
  ) else $error("read chunk size out of range");

endmodule
